// File: rtl/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg
// Item types and fixed constants shared by the coverage shader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcs_pkg;

  localparam int LANES = 3;
  localparam int CHAN_BITS = 8;

  typedef struct packed {
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;
    logic [23:0]        colour_a;
    logic [23:0]        colour_b;
    logic [23:0]        colour_c;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
  } tpcs_in_t;

  typedef struct packed {
    logic                 inside_res;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } tpcs_out_t;

endpackage

`default_nettype wire

// File: rtl/tpcs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tpcs_sqrt_cell
// One root bit of a floor square root, three lanes, with a registered hop.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcs_sqrt_cell #(
  parameter int RW  = 18,
  parameter int SBW = 1
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   ce_i,
  input  wire logic                                   valid_i,
  input  wire logic [tpcs_pkg::LANES-1:0][2*RW-1:0]   rad_i,
  input  wire logic [tpcs_pkg::LANES-1:0][RW+1:0]     rem_i,
  input  wire logic [tpcs_pkg::LANES-1:0][RW-1:0]     root_i,
  input  wire logic [SBW-1:0]                         sb_i,
  output logic                                        valid_o,
  output logic [tpcs_pkg::LANES-1:0][2*RW-1:0]        rad_o,
  output logic [tpcs_pkg::LANES-1:0][RW+1:0]          rem_o,
  output logic [tpcs_pkg::LANES-1:0][RW-1:0]          root_o,
  output logic [SBW-1:0]                              sb_o
);
  import tpcs_pkg::*;

  logic [LANES-1:0][2*RW-1:0] rad_d;
  logic [LANES-1:0][RW+1:0]   rem_d;
  logic [LANES-1:0][RW-1:0]   root_d;
  logic [LANES-1:0][RW+1:0]   rem_sh;
  logic [LANES-1:0][RW+1:0]   trial;
  logic                       valid_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_sh[l] = {rem_i[l][RW-1:0], rad_i[l][2*RW-1 -: 2]};
      trial[l]  = {root_i[l], 2'b01};
      rad_d[l]  = {rad_i[l][2*RW-3:0], 2'b00};
      if (rem_sh[l] >= trial[l]) begin
        rem_d[l]  = rem_sh[l] - trial[l];
        root_d[l] = {root_i[l][RW-2:0], 1'b1};
      end else begin
        rem_d[l]  = rem_sh[l];
        root_d[l] = {root_i[l][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rad_o  <= rad_d;
      rem_o  <= rem_d;
      root_o <= root_d;
      sb_o   <= sb_i;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: rtl/tpcs_div_cell.sv
// ----------------------------------------------------------------------------
// tpcs_div_cell
// One quotient bit of a restoring divide, three lanes sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcs_div_cell #(
  parameter int NW    = 28,
  parameter int TW    = 20,
  parameter int SHIFT = 7,
  parameter int SBW   = 1
) (
  input  wire logic                                                  clk_i,
  input  wire logic                                                  rst_ni,
  input  wire logic                                                  ce_i,
  input  wire logic                                                  valid_i,
  input  wire logic [tpcs_pkg::LANES-1:0][NW-1:0]                    rem_i,
  input  wire logic [tpcs_pkg::LANES-1:0][tpcs_pkg::CHAN_BITS-1:0]   quo_i,
  input  wire logic [TW-1:0]                                         total_i,
  input  wire logic [SBW-1:0]                                        sb_i,
  output logic                                                       valid_o,
  output logic [tpcs_pkg::LANES-1:0][NW-1:0]                         rem_o,
  output logic [tpcs_pkg::LANES-1:0][tpcs_pkg::CHAN_BITS-1:0]        quo_o,
  output logic [TW-1:0]                                              total_o,
  output logic [SBW-1:0]                                             sb_o
);
  import tpcs_pkg::*;

  logic [NW-1:0]                        cmp;
  logic [LANES-1:0][NW-1:0]             rem_d;
  logic [LANES-1:0][CHAN_BITS-1:0]      quo_d;
  logic                                 valid_q;

  assign cmp = NW'(total_i) << SHIFT;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (rem_i[l] >= cmp) begin
        rem_d[l] = rem_i[l] - cmp;
        quo_d[l] = {quo_i[l][CHAN_BITS-2:0], 1'b1};
      end else begin
        rem_d[l] = rem_i[l];
        quo_d[l] = {quo_i[l][CHAN_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ce_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_o   <= rem_d;
      quo_o   <= quo_d;
      total_o <= total_i;
      sb_o    <= sb_i;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: rtl/triangle_pixel_coverage_shader.sv
// Pipeline: front stages, then the square root cells, which make up most of
// the depth with one root bit per cell, a register for the weighted sums
// and eight divide cells. Throughput: one item per cycle while the skid
// buffer is empty; a one-entry skid buffer takes a result when the output
// stalls and holds the pipeline while full. Reset clears only valid flags.
// ----------------------------------------------------------------------------
// triangle_pixel_coverage_shader
// Edge-function coverage test and distance-weighted color blend per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_pixel_coverage_shader #(
  parameter int COORD_FRAC_BITS  = 4,
  parameter int PIXEL_COORD_BITS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tpcs_pkg::tpcs_in_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tpcs_pkg::tpcs_out_t      out_item_o
);
  import tpcs_pkg::*;

  localparam int CW  = PIXEL_COORD_BITS + COORD_FRAC_BITS;
  localparam int DW  = ((CW > 16) ? CW : 16) + 2;
  localparam int XW  = 2 * DW + 1;
  localparam int RW  = DW;
  localparam int TW  = RW + 2;
  localparam int NW  = RW + 10;
  localparam int CSB = 1 + LANES * 24;

  logic ce;

  // ---------------- front stages ----------------
  logic [PIXEL_COORD_BITS-1:0]   pxm, pym;
  logic [CW-1:0]                 px, py;
  logic signed [DW-1:0]          pxs, pys;
  logic signed [LANES-1:0][DW-1:0] vx, vy;
  logic [LANES-1:0][23:0]        col_in;

  assign pxm = PIXEL_COORD_BITS'(in_item_i.pixel_x);
  assign pym = PIXEL_COORD_BITS'(in_item_i.pixel_y);
  assign px  = CW'(pxm) << COORD_FRAC_BITS;
  assign py  = CW'(pym) << COORD_FRAC_BITS;
  assign pxs = DW'(px);
  assign pys = DW'(py);

  assign vx[0] = DW'(in_item_i.vertex_a_x);
  assign vy[0] = DW'(in_item_i.vertex_a_y);
  assign vx[1] = DW'(in_item_i.vertex_b_x);
  assign vy[1] = DW'(in_item_i.vertex_b_y);
  assign vx[2] = DW'(in_item_i.vertex_c_x);
  assign vy[2] = DW'(in_item_i.vertex_c_y);
  assign col_in[0] = in_item_i.colour_a;
  assign col_in[1] = in_item_i.colour_b;
  assign col_in[2] = in_item_i.colour_c;

  logic [2:0] fv_q;

  logic signed [DW-1:0] qx_q [LANES];
  logic signed [DW-1:0] qy_q [LANES];
  logic signed [DW-1:0] ex_q [LANES];
  logic signed [DW-1:0] ey_q [LANES];
  logic [LANES-1:0][23:0] col1_q, col2_q, col3_q;

  logic signed [2*DW-1:0] pa_q [LANES];
  logic signed [2*DW-1:0] pb_q [LANES];
  logic signed [2*DW-1:0] sx_q [LANES];
  logic signed [2*DW-1:0] sy_q [LANES];

  logic signed [XW-1:0]   xprod [LANES];
  logic [LANES-1:0]       pos;
  logic                   inside3_q;
  logic [LANES-1:0][2*RW-1:0] rad3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (ce) begin
      fv_q <= {fv_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int l = 0; l < LANES; l++) begin
        qx_q[l] <= pxs - vx[l];
        qy_q[l] <= pys - vy[l];
        ex_q[l] <= vx[(l + 1) % LANES] - vx[l];
        ey_q[l] <= vy[(l + 1) % LANES] - vy[l];
      end
      col1_q <= col_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int l = 0; l < LANES; l++) begin
        pa_q[l] <= ex_q[l] * qy_q[l];
        pb_q[l] <= ey_q[l] * qx_q[l];
        sx_q[l] <= qx_q[l] * qx_q[l];
        sy_q[l] <= qy_q[l] * qy_q[l];
      end
      col2_q <= col1_q;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xprod[l] = XW'(pa_q[l]) - XW'(pb_q[l]);
      pos[l]   = (xprod[l] > 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      inside3_q <= ~|pos;
      for (int l = 0; l < LANES; l++) begin
        rad3_q[l] <= $unsigned(sx_q[l]) + $unsigned(sy_q[l]);
      end
      col3_q <= col2_q;
    end
  end

  // ---------------- square root chain ----------------
  logic                               sq_v    [RW+1];
  logic [LANES-1:0][2*RW-1:0]         sq_rad  [RW+1];
  logic [LANES-1:0][RW+1:0]           sq_rem  [RW+1];
  logic [LANES-1:0][RW-1:0]           sq_root [RW+1];
  logic [CSB-1:0]                     sq_sb   [RW+1];

  assign sq_v[0]    = fv_q[2];
  assign sq_rad[0]  = rad3_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = {inside3_q, col3_q};

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    tpcs_sqrt_cell #(
      .RW  (RW),
      .SBW (CSB)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .valid_i (sq_v[j]),
      .rad_i   (sq_rad[j]),
      .rem_i   (sq_rem[j]),
      .root_i  (sq_root[j]),
      .sb_i    (sq_sb[j]),
      .valid_o (sq_v[j+1]),
      .rad_o   (sq_rad[j+1]),
      .rem_o   (sq_rem[j+1]),
      .root_o  (sq_root[j+1]),
      .sb_o    (sq_sb[j+1])
    );
  end

  // ---------------- weighted sums ----------------
  logic [LANES-1:0][23:0]     col_s;
  logic [LANES-1:0][NW-1:0]   num_d;
  logic [TW-1:0]              total_d;
  logic                       mv_q;
  logic [LANES-1:0][NW-1:0]   num_q;
  logic [TW-1:0]              total_q;
  logic                       minside_q, mblack_q;

  assign col_s = sq_sb[RW][CSB-2:0];

  always_comb begin
    total_d = TW'(sq_root[RW][0]) + TW'(sq_root[RW][1]) + TW'(sq_root[RW][2]);
    for (int ch = 0; ch < LANES; ch++) begin
      num_d[ch] = '0;
      for (int l = 0; l < LANES; l++) begin
        num_d[ch] = num_d[ch] + NW'(col_s[l][23 - 8*ch -: 8]) * NW'(sq_root[RW][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (ce) begin
      mv_q <= sq_v[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      num_q     <= num_d;
      total_q   <= total_d;
      minside_q <= sq_sb[RW][CSB-1];
      mblack_q  <= !sq_sb[RW][CSB-1] || (total_d == '0);
    end
  end

  // ---------------- divide chain ----------------
  logic                              dv_v   [CHAN_BITS+1];
  logic [LANES-1:0][NW-1:0]          dv_rem [CHAN_BITS+1];
  logic [LANES-1:0][CHAN_BITS-1:0]   dv_quo [CHAN_BITS+1];
  logic [TW-1:0]                     dv_tot [CHAN_BITS+1];
  logic [1:0]                        dv_sb  [CHAN_BITS+1];

  assign dv_v[0]   = mv_q;
  assign dv_rem[0] = num_q;
  assign dv_quo[0] = '0;
  assign dv_tot[0] = total_q;
  assign dv_sb[0]  = {minside_q, mblack_q};

  for (genvar j = 0; j < CHAN_BITS; j++) begin : g_div
    tpcs_div_cell #(
      .NW    (NW),
      .TW    (TW),
      .SHIFT (CHAN_BITS - 1 - j),
      .SBW   (2)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ce_i    (ce),
      .valid_i (dv_v[j]),
      .rem_i   (dv_rem[j]),
      .quo_i   (dv_quo[j]),
      .total_i (dv_tot[j]),
      .sb_i    (dv_sb[j]),
      .valid_o (dv_v[j+1]),
      .rem_o   (dv_rem[j+1]),
      .quo_o   (dv_quo[j+1]),
      .total_o (dv_tot[j+1]),
      .sb_o    (dv_sb[j+1])
    );
  end

  // ---------------- output and skid ----------------
  tpcs_out_t pipe_out;
  logic      pipe_v;
  logic      skid_full_q;
  tpcs_out_t skid_q;

  assign pipe_v = dv_v[CHAN_BITS];

  always_comb begin
    pipe_out.inside_res = dv_sb[CHAN_BITS][1];
    if (dv_sb[CHAN_BITS][0]) begin
      pipe_out.red   = '0;
      pipe_out.green = '0;
      pipe_out.blue  = '0;
    end else begin
      pipe_out.red   = dv_quo[CHAN_BITS][0];
      pipe_out.green = dv_quo[CHAN_BITS][1];
      pipe_out.blue  = dv_quo[CHAN_BITS][2];
    end
  end

  assign ce          = !skid_full_q;
  assign in_ready_o  = ce;
  assign out_valid_o = skid_full_q || pipe_v;
  assign out_item_o  = skid_full_q ? skid_q : pipe_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      skid_full_q <= !out_ready_i;
    end else begin
      skid_full_q <= pipe_v && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_q <= pipe_out;
    end
  end

`ifndef NO_ASSERTIONS
  a_black_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.inside_res) |->
      (out_item_o.red == '0 && out_item_o.green == '0 && out_item_o.blue == '0))
    else $error("colored result for uncovered pixel");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && !out_ready_i) |=> (skid_full_q && $stable(skid_q)))
    else $error("skid buffer lost a stalled result");

  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!skid_full_q && pipe_v && !out_ready_i) |=> skid_full_q)
    else $error("stalled result not captured");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tpcs_checker.sv
// ----------------------------------------------------------------------------
// tpcs_checker
// Watches both channels of the coverage shader, computes the expected
// coverage and blended color of every accepted item, and compares each
// accepted result against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tpcs_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  tpcs_pkg::tpcs_in_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  tpcs_pkg::tpcs_out_t out_item_i,
  output int                  errors_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 4;

  tpcs_pkg::tpcs_out_t pixel_q[$];

  function automatic longint isqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint edge_fn(longint x0, longint y0, longint x1, longint y1,
                                     longint px, longint py);
    return (x1 - x0) * (py - y0) - (y1 - y0) * (px - x0);
  endfunction

  function automatic longint vdist(longint vx, longint vy, longint px, longint py);
    return isqrt((px - vx) * (px - vx) + (py - vy) * (py - vy));
  endfunction

  function automatic tpcs_pkg::tpcs_out_t shade_pixel(tpcs_pkg::tpcs_in_t it);
    tpcs_pkg::tpcs_out_t r;
    longint ax, ay, bx, by, cx, cy, px, py, da, db, dc, tot, v;
    logic [7:0] ca, cb, cc;
    ax = it.vertex_a_x; ay = it.vertex_a_y;
    bx = it.vertex_b_x; by = it.vertex_b_y;
    cx = it.vertex_c_x; cy = it.vertex_c_y;
    px = longint'(it.pixel_x) << FRAC;
    py = longint'(it.pixel_y) << FRAC;
    r = '0;
    if (edge_fn(ax, ay, bx, by, px, py) > 0 || edge_fn(bx, by, cx, cy, px, py) > 0 ||
        edge_fn(cx, cy, ax, ay, px, py) > 0) return r;
    r.inside_res = 1'b1;
    da = vdist(ax, ay, px, py);
    db = vdist(bx, by, px, py);
    dc = vdist(cx, cy, px, py);
    tot = da + db + dc;
    if (tot == 0) return r;
    for (int ch = 0; ch < 3; ch++) begin
      ca = it.colour_a >> (16 - 8 * ch);
      cb = it.colour_b >> (16 - 8 * ch);
      cc = it.colour_c >> (16 - 8 * ch);
      v = (ca * da + cb * db + cc * dc) / tot;
      if (v > 255) v = 255;
      case (ch)
        0: r.red = v[7:0];
        1: r.green = v[7:0];
        default: r.blue = v[7:0];
      endcase
    end
    return r;
  endfunction

  assign pending_o = pixel_q.size();

  initial errors_o = 0;

  always @(posedge clk_i) begin
    tpcs_pkg::tpcs_out_t exp_px;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) pixel_q.push_back(shade_pixel(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_px = pixel_q.pop_front();
          if (exp_px !== out_item_i) begin
            $display("%0t: mismatch expected in=%0b r=%0d g=%0d b=%0d actual in=%0b r=%0d g=%0d b=%0d",
                     $time, exp_px.inside_res, exp_px.red, exp_px.green, exp_px.blue,
                     out_item_i.inside_res, out_item_i.red, out_item_i.green,
                     out_item_i.blue);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/tb_triangle_pixel_coverage_shader.sv
// ----------------------------------------------------------------------------
// tb_triangle_pixel_coverage_shader
// Drives directed and random triangles and pixels with random gaps and
// output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_triangle_pixel_coverage_shader;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1300;
  localparam int WATCHDOG = 5000;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  tpcs_pkg::tpcs_in_t  in_item;
  tpcs_pkg::tpcs_out_t out_item;
  int errors, pending, idle_cycles;

  triangle_pixel_coverage_shader dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_item_i(in_item), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_item_o(out_item)
  );

  tpcs_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_item_i(in_item), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_item_i(out_item), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rcoord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 4095) << 4) | 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 255) << 4);
    endcase
  endfunction

  task automatic send_item(tpcs_pkg::tpcs_in_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic tpcs_pkg::tpcs_in_t mk_tri(int ax, int ay, int bx, int by, int cx,
                                                int cy, int px, int py);
    tpcs_pkg::tpcs_in_t it;
    it.vertex_a_x = 16'(ax); it.vertex_a_y = 16'(ay);
    it.vertex_b_x = 16'(bx); it.vertex_b_y = 16'(by);
    it.vertex_c_x = 16'(cx); it.vertex_c_y = 16'(cy);
    it.colour_a = 24'hFF0000; it.colour_b = 24'h00FF00; it.colour_c = 24'h0000FF;
    it.pixel_x = 12'(px); it.pixel_y = 12'(py);
    return it;
  endfunction

  // out_ready stalls
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_triangle_pixel_coverage_shader NOT OK");
      $finish;
    end
  end

  initial begin
    tpcs_pkg::tpcs_in_t it;
    int sz, ox, oy;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: winding both ways, edges, vertices, degenerate, extremes
    send_item(mk_tri(0, 0, 0, 160, 160, 0, 2, 2));
    send_item(mk_tri(0, 0, 160, 0, 0, 160, 2, 2));
    send_item(mk_tri(0, 0, 0, 160, 160, 0, 20, 20));
    send_item(mk_tri(0, 0, 0, 160, 160, 0, 0, 0));
    send_item(mk_tri(0, 0, 0, 160, 160, 0, 5, 0));
    send_item(mk_tri(32, 48, 32, 48, 32, 48, 2, 3));
    send_item(mk_tri(32, 48, 32, 48, 32, 48, 2, 4));
    send_item(mk_tri(0, 0, 16, 16, 32, 32, 1, 1));
    send_item(mk_tri(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0));
    send_item(mk_tri(-32768, -32768, -32768, 32767, 32767, 32767, 4095, 4095));
    send_item(mk_tri(32767, 32767, 32767, -32768, -32768, 32767, 4095, 0));
    send_item(mk_tri(-32768, 32767, 32767, 32767, -32768, -32768, 0, 4095));
    send_item(mk_tri(0, 0, 0, 0, 0, 0, 4095, 4095));
    it = mk_tri(-32768, -32768, -32768, 32767, 32767, -32768, 100, 100);
    it.colour_a = 24'hFFFFFF; it.colour_b = 24'hFFFFFF; it.colour_c = 24'hFFFFFF;
    send_item(it);
    it.colour_a = 24'h0; it.colour_b = 24'h0; it.colour_c = 24'h0;
    send_item(it);
    it.colour_a = 24'h123456; it.colour_b = 24'hFEDCBA; it.colour_c = 24'hA5A5A5;
    send_item(it);
    for (int i = 0; i < N_RANDOM; i++) begin
      it.colour_a = 24'($urandom); it.colour_b = 24'($urandom);
      it.colour_c = 24'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        it.vertex_a_x = rcoord(); it.vertex_a_y = rcoord();
        it.vertex_b_x = rcoord(); it.vertex_b_y = rcoord();
        it.vertex_c_x = rcoord(); it.vertex_c_y = rcoord();
        it.pixel_x = 12'($urandom); it.pixel_y = 12'($urandom);
      end else begin
        // triangle around the pixel, either winding
        sz = ($urandom_range(0, 9) == 0) ? 30000 : $urandom_range(1, 400);
        it.pixel_x = 12'($urandom); it.pixel_y = 12'($urandom);
        ox = int'(it.pixel_x) * 16; oy = int'(it.pixel_y) * 16;
        if (ox > 32767 - 2 * sz) ox = 32767 - 2 * sz;
        if (oy > 32767 - 2 * sz) oy = 32767 - 2 * sz;
        it.vertex_a_x = 16'(ox - $urandom_range(0, sz));
        it.vertex_a_y = 16'(oy - $urandom_range(0, sz));
        it.vertex_b_x = 16'(ox - $urandom_range(0, sz));
        it.vertex_b_y = 16'(oy + $urandom_range(0, 2 * sz));
        it.vertex_c_x = 16'(ox + $urandom_range(0, 2 * sz));
        it.vertex_c_y = 16'(oy - $urandom_range(0, sz));
        if ($urandom_range(0, 3) == 0) begin
          it.vertex_c_x = it.vertex_b_x; it.vertex_c_y = it.vertex_b_y;
          it.vertex_b_x = 16'(ox + $urandom_range(0, 2 * sz));
          it.vertex_b_y = 16'(oy - $urandom_range(0, sz));
        end
      end
      send_item(it);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_triangle_pixel_coverage_shader OK");
    end else begin
      $display("tb_triangle_pixel_coverage_shader NOT OK");
    end
    $finish;
  end
endmodule
